// ----- rtl/vgb_pkg.sv -----
// ----------------------------------------------------------------------------
// vgb_pkg
// Shared types and constants of the velocity grid binning block.
// ----------------------------------------------------------------------------
package vgb_pkg;

   // operation codes carried on the request channel
   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_DEPOSIT   = 2'd1,
      OP_NORMALIZE = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   // grid size register
   localparam int          GSIZE_W     = 7;
   localparam logic [6:0]  GSIZE_RESET = 7'd64;

   // cell word: {sum_vx, sum_vy, count}
   localparam int           SUM_W      = 32;
   localparam int           CNT_W      = 16;
   localparam int           WORD_W     = 2 * SUM_W + CNT_W;
   localparam logic [15:0]  COUNT_FULL = 16'hFFFF;

   // classified command, address travels beside it
   typedef struct packed {
      op_type      op;
      logic        on_grid;
      logic        interior;
      logic [15:0] vel_x;
      logic [15:0] vel_y;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [3:0] {
      BK_INIT,
      BK_IDLE,
      BK_DEP,
      BK_CLR,
      BK_NRM_RD,
      BK_NRM_CHK,
      BK_NRM_DIV,
      BK_QRY,
      BK_QCALC,
      BK_RESP
   } state_type;

endpackage

// ----- rtl/vgb_if.sv -----
// ----------------------------------------------------------------------------
// vgb_if
// Channel interfaces: request, response and register write.
// ----------------------------------------------------------------------------
interface vgb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;

   modport source (output valid, opcode, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface vgb_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] vx_out;
   logic signed [31:0] vy_out;
   logic [15:0]        density_out;
   logic signed [32:0] divergence_out;
   logic signed [32:0] curl_out;

   modport source (output valid, status, vx_out, vy_out, density_out,
                   divergence_out, curl_out, input ready);
   modport sink   (input valid, status, vx_out, vy_out, density_out,
                   divergence_out, curl_out, output ready);
endinterface

interface vgb_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/vgb_ram.sv -----
// ----------------------------------------------------------------------------
// vgb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/vgb_fifo.sv -----
// ----------------------------------------------------------------------------
// vgb_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module vgb_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             in_ready,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ----- rtl/vgb_front.sv -----
// ----------------------------------------------------------------------------
// vgb_front
// Accepts requests, holds the grid size register, bins the position into a
// cell address and classifies it (on grid, interior) for the back end.
// ----------------------------------------------------------------------------
module vgb_front #(
   parameter int GRID_MAX = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   vgb_req_if.sink                                req,
   vgb_csr_if.sink                                csr,
   input  logic                                   init_busy,
   input  logic                                   q_ready,
   output logic                                   q_push,
   output vgb_pkg::cmd_type                       q_cmd,
   output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]   q_addr
);
   import vgb_pkg::*;

   localparam int CW = $clog2(GRID_MAX);
   localparam int AW = $clog2(GRID_MAX * GRID_MAX);

   logic [GSIZE_W-1:0] grid_size_ff, grid_size_in;
   logic [8:0]         nsz;
   logic [7:0]         cx, cy;
   logic               x_ok, y_ok, x_in, y_in;
   logic               x_int, y_int;
   logic [CW-1:0]      gx, gy;

   // register write, always ready
   assign csr.ready    = 1'b1;
   assign grid_size_in = (csr.valid) ? csr.data : grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GSIZE_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   // size in use, clamped to the grid storage
   assign nsz = (9'(grid_size_ff) > 9'(GRID_MAX)) ? 9'(GRID_MAX) : 9'(grid_size_ff);

   // truncate toward zero: (-1,0) lands in cell 0, anything lower is outside
   assign cx   = req.pos_x[15] ? 8'd0 : {1'b0, req.pos_x[14:8]};
   assign cy   = req.pos_y[15] ? 8'd0 : {1'b0, req.pos_y[14:8]};
   assign x_ok = !req.pos_x[15] || ((req.pos_x[15:8] == 8'hFF) && (req.pos_x[7:0] != 8'h00));
   assign y_ok = !req.pos_y[15] || ((req.pos_y[15:8] == 8'hFF) && (req.pos_y[7:0] != 8'h00));
   assign x_in = x_ok && (9'(cx) < nsz);
   assign y_in = y_ok && (9'(cy) < nsz);

   // interior cells have all four neighbors inside the grid
   assign x_int = (cx != 8'd0) && ((9'(cx) + 9'd1) < nsz);
   assign y_int = (cy != 8'd0) && ((9'(cy) + 9'd1) < nsz);

   assign gx = CW'(cx);
   assign gy = CW'(cy);

   // hand the classified command to the queue
   assign req.ready      = q_ready && !init_busy;
   assign q_push         = req.valid && req.ready;
   assign q_cmd.op       = op_type'(req.opcode);
   assign q_cmd.on_grid  = x_in && y_in;
   assign q_cmd.interior = x_int && y_int;
   assign q_cmd.vel_x    = req.vel_x;
   assign q_cmd.vel_y    = req.vel_y;
   assign q_addr         = AW'(gy) * AW'(GRID_MAX) + AW'(gx);
endmodule

// ----- rtl/vgb_div.sv -----
// ----------------------------------------------------------------------------
// vgb_div
// Bit-serial signed by unsigned divider, truncating toward zero.
// One quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module vgb_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic [15:0]        divisor,
   output logic               done,
   output logic signed [31:0] quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] dq_ff, dq_in;
   logic        neg_ff, neg_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] rem_sh;
   logic        ge;

   // restoring step
   assign rem_sh = {rem_ff, dq_ff[31]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 16'd0;
         neg_in  = dividend[31];
         dq_in   = dividend[31] ? 32'(-dividend) : dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? 16'(rem_sh - {1'b0, dvs_ff}) : rem_sh[15:0];
         dq_in   = {dq_ff[30:0], ge};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(dq_ff) : signed'(dq_ff);
endmodule

// ----- rtl/vgb_back.sv -----
// ----------------------------------------------------------------------------
// vgb_back
// Executes queued commands against the cell RAM: clear sweep, deposit
// read-modify-write, normalize sweep through the dividers, and query with
// neighbor reads for divergence and curl. Owns the response register.
// ----------------------------------------------------------------------------
module vgb_back #(
   parameter int GRID_MAX = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  vgb_pkg::cmd_type                     q_cmd,
   input  logic [$clog2(GRID_MAX*GRID_MAX)-1:0] q_addr,
   output logic                                 q_pop,
   output logic                                 init_busy,
   vgb_rsp_if.source                            rsp
);
   import vgb_pkg::*;

   localparam int CELLS = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(CELLS);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   logic [2:0]         ph_ff, ph_in;
   logic [CNT_W-1:0]   ncnt_ff, ncnt_in;
   logic [1:0]         res_stat_ff, res_stat_in;
   logic [SUM_W-1:0]   res_vx_ff, res_vx_in;
   logic [SUM_W-1:0]   res_vy_ff, res_vy_in;
   logic [CNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic signed [33:0] acc_d_ff, acc_d_in;
   logic signed [33:0] acc_c_ff, acc_c_in;
   logic [32:0]        res_div_ff, res_div_in;
   logic [32:0]        res_curl_ff, res_curl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_stat_ff;
   logic [SUM_W-1:0]   rsp_vx_ff, rsp_vy_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic [32:0]        rsp_div_ff, rsp_curl_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [WORD_W-1:0]  ram_wdata, ram_rdata;
   logic [SUM_W-1:0]   rd_vx, rd_vy;
   logic [CNT_W-1:0]   rd_cnt;
   logic signed [33:0] rd_vx34, rd_vy34;
   logic               sweep_last, out_free, rsp_load;
   logic               div_start, div_done_x, div_done_y;
   logic signed [31:0] quot_x, quot_y;
   logic signed [33:0] half_d, half_c;

   // cell storage
   vgb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // averaging dividers, one per component
   vgb_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (signed'(rd_vx)),
      .divisor  (rd_cnt),
      .done     (div_done_x),
      .quotient (quot_x)
   );

   vgb_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (signed'(rd_vy)),
      .divisor  (rd_cnt),
      .done     (div_done_y),
      .quotient (quot_y)
   );

   assign rd_vx      = ram_rdata[WORD_W-1 -: SUM_W];
   assign rd_vy      = ram_rdata[CNT_W +: SUM_W];
   assign rd_cnt     = ram_rdata[CNT_W-1:0];
   assign rd_vx34    = {{2{rd_vx[31]}}, rd_vx};
   assign rd_vy34    = {{2{rd_vy[31]}}, rd_vy};
   assign sweep_last = (sweep_ff == AW'(CELLS - 1));
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign init_busy  = (state_ff == BK_INIT);

   // halve toward zero
   assign half_d = acc_d_ff + {33'd0, acc_d_ff[33]};
   assign half_c = acc_c_ff + {33'd0, acc_c_ff[33]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_INIT: begin
            if (sweep_last) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_CLEAR:     state_in = BK_CLR;
                  OP_DEPOSIT:   state_in = q_cmd.on_grid ? BK_DEP : BK_RESP;
                  OP_NORMALIZE: state_in = BK_NRM_RD;
                  OP_QUERY:     state_in = q_cmd.on_grid ? BK_QRY : BK_RESP;
                  default:      state_in = BK_RESP;
               endcase
            end
         end
         BK_DEP:    state_in = BK_RESP;
         BK_CLR: begin
            if (sweep_last) state_in = BK_RESP;
         end
         BK_NRM_RD: state_in = BK_NRM_CHK;
         BK_NRM_CHK: begin
            if (rd_cnt != '0) begin
               state_in = BK_NRM_DIV;
            end else begin
               state_in = sweep_last ? BK_RESP : BK_NRM_RD;
            end
         end
         BK_NRM_DIV: begin
            if (div_done_x) state_in = sweep_last ? BK_RESP : BK_NRM_RD;
         end
         BK_QRY: begin
            if (ph_ff == 3'd0 && !cmd_ff.interior) begin
               state_in = BK_RESP;
            end else if (ph_ff == 3'd4) begin
               state_in = BK_QCALC;
            end
         end
         BK_QCALC:  state_in = BK_RESP;
         BK_RESP: begin
            if (out_free) state_in = BK_IDLE;
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs: queue pop, RAM port, divider start
   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = sweep_ff;
      ram_wdata = '0;
      ram_raddr = addr_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         BK_INIT, BK_CLR: begin
            ram_we = 1'b1;
         end
         BK_IDLE: begin
            q_pop     = q_valid;
            ram_raddr = q_addr;
         end
         BK_DEP: begin
            ram_waddr = addr_ff;
            ram_we    = (rd_cnt != COUNT_FULL);
            ram_wdata = {rd_vx + {{16{cmd_ff.vel_x[15]}}, cmd_ff.vel_x},
                         rd_vy + {{16{cmd_ff.vel_y[15]}}, cmd_ff.vel_y},
                         rd_cnt + 16'd1};
         end
         BK_NRM_RD: begin
            ram_raddr = sweep_ff;
         end
         BK_NRM_CHK: begin
            div_start = (rd_cnt != '0);
         end
         BK_NRM_DIV: begin
            ram_we    = div_done_x;
            ram_wdata = {quot_x, quot_y, ncnt_ff};
         end
         BK_QRY: begin
            case (ph_ff)
               3'd0:    ram_raddr = addr_ff - AW'(1);
               3'd1:    ram_raddr = addr_ff + AW'(1);
               3'd2:    ram_raddr = addr_ff - AW'(GRID_MAX);
               3'd3:    ram_raddr = addr_ff + AW'(GRID_MAX);
               default: ram_raddr = addr_ff;
            endcase
         end
         BK_RESP: begin
            rsp_load = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // datapath register updates
   always_comb begin
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      sweep_in    = sweep_ff;
      ph_in       = ph_ff;
      ncnt_in     = ncnt_ff;
      res_stat_in = res_stat_ff;
      res_vx_in   = res_vx_ff;
      res_vy_in   = res_vy_ff;
      res_cnt_in  = res_cnt_ff;
      acc_d_in    = acc_d_ff;
      acc_c_in    = acc_c_ff;
      res_div_in  = res_div_ff;
      res_curl_in = res_curl_ff;
      case (state_ff)
         BK_INIT, BK_CLR: begin
            sweep_in = sweep_ff + AW'(1);
         end
         BK_IDLE: begin
            cmd_in      = q_cmd;
            addr_in     = q_addr;
            sweep_in    = '0;
            ph_in       = 3'd0;
            res_vx_in   = '0;
            res_vy_in   = '0;
            res_cnt_in  = '0;
            acc_d_in    = '0;
            acc_c_in    = '0;
            res_div_in  = '0;
            res_curl_in = '0;
            res_stat_in = STAT_OK;
            if ((q_cmd.op == OP_DEPOSIT || q_cmd.op == OP_QUERY) && !q_cmd.on_grid) begin
               res_stat_in = STAT_OUTSIDE;
            end
         end
         BK_DEP: begin
            if (rd_cnt == COUNT_FULL) res_stat_in = STAT_FULL;
         end
         BK_NRM_CHK: begin
            ncnt_in = rd_cnt;
            if (rd_cnt == '0) sweep_in = sweep_ff + AW'(1);
         end
         BK_NRM_DIV: begin
            if (div_done_x) sweep_in = sweep_ff + AW'(1);
         end
         BK_QRY: begin
            ph_in = ph_ff + 3'd1;
            // accumulate one neighbor per cycle
            case (ph_ff)
               3'd0: begin
                  res_vx_in  = rd_vx;
                  res_vy_in  = rd_vy;
                  res_cnt_in = rd_cnt;
               end
               3'd1: begin
                  acc_d_in = acc_d_ff - rd_vx34;
                  acc_c_in = acc_c_ff - rd_vy34;
               end
               3'd2: begin
                  acc_d_in = acc_d_ff + rd_vx34;
                  acc_c_in = acc_c_ff + rd_vy34;
               end
               3'd3: begin
                  acc_d_in = acc_d_ff - rd_vy34;
                  acc_c_in = acc_c_ff + rd_vx34;
               end
               default: begin
                  acc_d_in = acc_d_ff + rd_vy34;
                  acc_c_in = acc_c_ff - rd_vx34;
               end
            endcase
         end
         BK_QCALC: begin
            res_div_in  = half_d[33:1];
            res_curl_in = half_c[33:1];
         end
         default: begin
            ph_in = ph_ff;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         sweep_ff     <= '0;
         ph_ff        <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      ncnt_ff     <= ncnt_in;
      res_stat_ff <= res_stat_in;
      res_vx_ff   <= res_vx_in;
      res_vy_ff   <= res_vy_in;
      res_cnt_ff  <= res_cnt_in;
      acc_d_ff    <= acc_d_in;
      acc_c_ff    <= acc_c_in;
      res_div_ff  <= res_div_in;
      res_curl_ff <= res_curl_in;
      if (rsp_load) begin
         rsp_stat_ff <= res_stat_ff;
         rsp_vx_ff   <= res_vx_ff;
         rsp_vy_ff   <= res_vy_ff;
         rsp_cnt_ff  <= res_cnt_ff;
         rsp_div_ff  <= res_div_ff;
         rsp_curl_ff <= res_curl_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_stat_ff;
   assign rsp.vx_out         = rsp_vx_ff;
   assign rsp.vy_out         = rsp_vy_ff;
   assign rsp.density_out    = rsp_cnt_ff;
   assign rsp.divergence_out = rsp_div_ff;
   assign rsp.curl_out       = rsp_curl_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("queue popped outside idle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_INIT) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      div_done_x |-> (div_done_y && state_ff == BK_NRM_DIV))
      else $error("dividers out of step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_QRY) |-> (ph_ff <= 3'd4))
      else $error("query phase overrun");
endmodule

// ----- rtl/velocity_grid_binning_divergence_curl.sv -----
// ----------------------------------------------------------------------------
// velocity_grid_binning_divergence_curl
// Particle-to-grid velocity binning with central-difference divergence/curl.
// ----------------------------------------------------------------------------
// One request gives one response. After reset the block sweeps the cell RAM
// to zero with req.ready low. Commands then run one at a time out of a
// two-entry queue, paced by the cell RAM (one read, one write port): deposit
// reads, writes and responds, and responds at once when outside the grid;
// query responds at once outside, reads the cell on a border and reads it
// and its four neighbors inside (five reads); clear sweeps every cell;
// normalize reads each cell and runs occupied ones through the bit-serial
// dividers, writing the averages back. A response that is not taken holds
// the back end; the queue then fills and the request side stalls.
// ----------------------------------------------------------------------------
module velocity_grid_binning_divergence_curl #(
   parameter int GRID_MAX = 64
) (
   input  logic      clock,
   input  logic      reset,
   vgb_req_if.sink   req_ch,
   vgb_rsp_if.source rsp_ch,
   vgb_csr_if.sink   csr_ch
);
   import vgb_pkg::*;

   localparam int AW = $clog2(GRID_MAX * GRID_MAX);
   localparam int QW = AW + $bits(cmd_type);

   logic          init_busy;
   logic          q_push, q_ready, q_pop, q_valid;
   cmd_type       f_cmd, b_cmd;
   logic [AW-1:0] f_addr, b_addr;
   logic [QW-1:0] q_out;

   // front end: accept and classify
   vgb_front #(
      .GRID_MAX (GRID_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .init_busy (init_busy),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_cmd     (f_cmd),
      .q_addr    (f_addr)
   );

   // command queue
   vgb_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_addr, f_cmd}),
      .in_ready  (q_ready),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_out)
   );

   assign b_addr = q_out[QW-1 -: AW];
   assign b_cmd  = cmd_type'(q_out[$bits(cmd_type)-1:0]);

   // back end: execute against the cell RAM
   vgb_back #(
      .GRID_MAX (GRID_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (b_cmd),
      .q_addr    (b_addr),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp       (rsp_ch)
   );
endmodule
